FILE: design/tte_pkg.sv
// Shared types and constants for the transposition table engine.
`timescale 1ns / 1ps

package tte_pkg;

    // Request codes
    localparam logic REQ_PROBE = 1'b0;
    localparam logic REQ_STORE = 1'b1;

    // Stored bound kinds
    localparam logic [1:0] KIND_ALL   = 2'd0;
    localparam logic [1:0] KIND_CUT   = 2'd1;
    localparam logic [1:0] KIND_EXACT = 2'd2;

    // Probe outcome codes
    localparam logic [1:0] OUT_CONTINUE = 2'd0;
    localparam logic [1:0] OUT_EXACT    = 2'd1;
    localparam logic [1:0] OUT_BETA     = 2'd2;

    localparam int FILL_W = 11;
    localparam logic [FILL_W-1:0] FILL_MAX = '1;

    typedef struct packed {
        logic       valid;
        logic [1:0] kind;
        logic [7:0] depth;
    } info_t;

    typedef struct packed {
        logic [63:0]        tag;
        logic [31:0]        move;
        logic signed [31:0] score;
        info_t              info;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load_req;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: design/tte_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module tte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/tte_ctrl.sv
// Sequencing state machine: clearing pass, request accept, lookup and finish.
`timescale 1ns / 1ps

module tte_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tte_pkg::dp_status_t status,
    output tte_pkg::ctrl_cmd_t  cmd
);

    import tte_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                // wait until the result register is free
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

FILE: design/tte_datapath.sv
// Request registers, slot memory, probe/store evaluation and result register.
`timescale 1ns / 1ps

module tte_datapath #(
    parameter int INDEX_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tte_pkg::ctrl_cmd_t         cmd,
    output tte_pkg::dp_status_t        status,
    input  logic                       req_type,
    input  logic [63:0]                key,
    input  logic [7:0]                 remaining_depth,
    input  logic signed [31:0]         window_low,
    input  logic signed [31:0]         window_high,
    input  logic signed [31:0]         entry_value,
    input  logic [1:0]                 entry_kind,
    input  logic [31:0]                entry_move,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic [31:0]                hint_move,
    output logic [1:0]                 outcome,
    output logic signed [31:0]         adjusted_low,
    output logic signed [31:0]         adjusted_high,
    output logic signed [31:0]         return_value,
    output logic                       written,
    output logic [tte_pkg::FILL_W-1:0] fill_count
);

    import tte_pkg::*;

    localparam int SLOT_COUNT = 1 << INDEX_BITS;

    // latched request
    logic               req_type_reg;
    logic [63:0]        key_reg;
    logic [7:0]         depth_reg;
    logic signed [31:0] lo_reg;
    logic signed [31:0] hi_reg;
    logic signed [31:0] val_reg;
    logic [1:0]         kind_reg;
    logic [31:0]        move_reg;

    logic [INDEX_BITS-1:0] clear_cnt_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;

    // result register
    logic               out_valid_reg;
    logic               hit_reg;
    logic [31:0]        hint_reg;
    logic [1:0]         outcome_reg;
    logic signed [31:0] adj_lo_reg;
    logic signed [31:0] adj_hi_reg;
    logic signed [31:0] ret_reg;
    logic               written_reg;

    logic [ENTRY_W-1:0]    ram_rdata;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [INDEX_BITS-1:0] ram_waddr;
    logic                  ram_we;
    entry_t                rd;
    entry_t                new_entry;

    logic               s_valid;
    logic signed [31:0] s_score;
    logic               tag_hit;
    logic               usable;
    logic               replace;
    logic               do_write;

    logic               hit_c;
    logic [31:0]        hint_c;
    logic [1:0]         outcome_c;
    logic signed [31:0] adj_lo_c;
    logic signed [31:0] adj_hi_c;
    logic signed [31:0] ret_c;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            key_reg      <= key;
            depth_reg    <= remaining_depth;
            lo_reg       <= window_low;
            hi_reg       <= window_high;
            val_reg      <= entry_value;
            kind_reg     <= entry_kind;
            move_reg     <= entry_move;
        end
    end

    tte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.load_req),
        .raddr (key[INDEX_BITS-1:0]),
        .rdata (ram_rdata)
    );

    assign rd      = entry_t'(ram_rdata);
    assign s_valid = rd.info.valid;
    assign s_score = rd.score;
    assign tag_hit = s_valid && (rd.tag == key_reg);
    assign usable  = rd.info.depth >= depth_reg;
    // an empty slot reads as all zero info, so its depth never blocks
    assign replace = (!s_valid || (rd.info.kind != KIND_EXACT)) && (rd.info.depth <= depth_reg);
    assign do_write = cmd.finish && (req_type_reg == REQ_STORE) && replace;

    always_comb
    begin
        new_entry.tag        = key_reg;
        new_entry.move       = move_reg;
        new_entry.score      = val_reg;
        new_entry.info.valid = 1'b1;
        new_entry.info.kind  = kind_reg;
        new_entry.info.depth = depth_reg;
    end

    // clearing pass owns the write port until it is done
    assign ram_we    = cmd.clear_wr || do_write;
    assign ram_waddr = cmd.clear_wr ? clear_cnt_reg : key_reg[INDEX_BITS-1:0];
    assign ram_wdata = cmd.clear_wr ? '0 : ENTRY_W'(new_entry);

    always_comb
    begin
        hit_c     = 1'b0;
        hint_c    = '0;
        outcome_c = OUT_CONTINUE;
        adj_lo_c  = '0;
        adj_hi_c  = '0;
        ret_c     = '0;
        if (req_type_reg == REQ_PROBE)
        begin
            adj_lo_c = lo_reg;
            adj_hi_c = hi_reg;
            if (tag_hit)
            begin
                hit_c  = 1'b1;
                hint_c = rd.move;
                if (usable)
                begin
                    if (rd.info.kind == KIND_EXACT)
                    begin
                        outcome_c = OUT_EXACT;
                        ret_c     = s_score;
                    end
                    else
                    begin
                        if ((rd.info.kind == KIND_CUT) && (s_score > lo_reg))
                        begin
                            adj_lo_c = s_score;
                        end
                        else if ((rd.info.kind == KIND_ALL) && (s_score < hi_reg))
                        begin
                            adj_hi_c = s_score;
                        end
                        if (adj_lo_c >= adj_hi_c)
                        begin
                            outcome_c = OUT_BETA;
                            ret_c     = adj_hi_c;
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (do_write && !s_valid && (fill_reg != FILL_MAX))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_cnt_reg <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
            end
            fill_reg <= fill_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            hit_reg     <= hit_c;
            hint_reg    <= hint_c;
            outcome_reg <= outcome_c;
            adj_lo_reg  <= adj_lo_c;
            adj_hi_reg  <= adj_hi_c;
            ret_reg     <= ret_c;
            written_reg <= do_write;
        end
    end

    assign status.clear_last = (clear_cnt_reg == '1);
    assign status.out_busy   = out_valid_reg && out_stall;

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign hint_move     = hint_reg;
    assign outcome       = outcome_reg;
    assign adjusted_low  = adj_lo_reg;
    assign adjusted_high = adj_hi_reg;
    assign return_value  = ret_reg;
    assign written       = written_reg;
    // changes only on finish, the same edge the result register loads
    assign fill_count    = fill_reg;

endmodule

FILE: design/transposition_table_engine.sv
// An input transfer latches the request and reads its slot; the result register then loads
//   once it is free. One request is in flight at a time, set by the single read-then-update access
//   of the slot memory; a stalled output holds the lookup until the result register frees.
// Reset: asynchronous, active low. After reset a clearing pass zeroes every one of the
//   2^INDEX_BITS slots (1024 by default) while in_stall stays high.
`timescale 1ns / 1ps

module transposition_table_engine #(
    parameter int INDEX_BITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       req_type,
    input  logic [63:0]                key,
    input  logic [7:0]                 remaining_depth,
    input  logic signed [31:0]         window_low,
    input  logic signed [31:0]         window_high,
    input  logic signed [31:0]         entry_value,
    input  logic [1:0]                 entry_kind,
    input  logic [31:0]                entry_move,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       hit,
    output logic [31:0]                hint_move,
    output logic [1:0]                 outcome,
    output logic signed [31:0]         adjusted_low,
    output logic signed [31:0]         adjusted_high,
    output logic signed [31:0]         return_value,
    output logic                       written,
    output logic [tte_pkg::FILL_W-1:0] fill_count
);

    import tte_pkg::*;

    // Controller sequences the work; the datapath owns the slot memory, the
    // request latch, the fill counter and the result register. They talk
    // only through the command and status structs below.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    tte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Each slot holds the full key as its tag, the move, the score and an
    // info field (valid, kind, depth). The info field of a cleared slot is
    // zero, so a store into an empty slot always replaces it.
    tte_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .req_type        (req_type),
        .key             (key),
        .remaining_depth (remaining_depth),
        .window_low      (window_low),
        .window_high     (window_high),
        .entry_value     (entry_value),
        .entry_kind      (entry_kind),
        .entry_move      (entry_move),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .hint_move       (hint_move),
        .outcome         (outcome),
        .adjusted_low    (adjusted_low),
        .adjusted_high   (adjusted_high),
        .return_value    (return_value),
        .written         (written),
        .fill_count      (fill_count)
    );

    // One request in flight: an accepted transfer closes the input next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in flight");

    // A store result carries no probe information.
    a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written |-> !hit && (outcome == OUT_CONTINUE) && (return_value == 0))
        else $error("store result carries probe fields");

    // Nothing to return when the search continues.
    a_continue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (outcome == OUT_CONTINUE) |-> (return_value == 0))
        else $error("nonzero return value with continue outcome");

    // A miss gives no hint and no early return.
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (hint_move == 0) && (outcome == OUT_CONTINUE))
        else $error("miss produced a hint or an outcome");

    // The fill counter saturates and never goes back.
    a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fill_count >= $past(fill_count))
        else $error("fill count decreased");

endmodule

FILE: sim/tb_transposition_table_engine.sv
// Self-checking bench for transposition_table_engine: random probes and stores vs a shadow table.
`timescale 1ns / 1ps

module tb_transposition_table_engine;
    import tte_pkg::*;

    // Table geometry matches the default build of the engine
    localparam int TBL_BITS  = 10;
    localparam int TBL_SLOTS = 1 << TBL_BITS;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 3;
    // Longest quiet stretch in a good run is the post-reset clear
    // or the receiver hold-off below; the limit is several times either.
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_ITEMS   = 24;
    localparam int RANDOM_ITEMS = 480;
    localparam int POOL_SIZE    = 64;
    localparam int DRAIN_CYCLES = 8;

    // Bound kind outside the three named ones: stored as is, never applied
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic               req;
        logic [63:0]        key;
        logic [7:0]         depth;
        logic signed [31:0] w_lo;
        logic signed [31:0] w_hi;
        logic signed [31:0] val;
        logic [1:0]         kind;
        logic [31:0]        mv;
    } tt_request_t;

    typedef struct packed {
        logic               hit;
        logic [31:0]        hint;
        logic [1:0]         outcome;
        logic signed [31:0] adj_lo;
        logic signed [31:0] adj_hi;
        logic signed [31:0] ret;
        logic               written;
        logic [FILL_W-1:0]  fill;
    } tt_result_t;

    // Shadow copy of the table; predicts every response and checks them in order.
    class table_shadow;
        logic [63:0]        slot_tag   [TBL_SLOTS];
        logic [31:0]        slot_move  [TBL_SLOTS];
        logic signed [31:0] slot_score [TBL_SLOTS];
        logic               slot_valid [TBL_SLOTS];
        logic [1:0]         slot_kind  [TBL_SLOTS];
        logic [7:0]         slot_depth [TBL_SLOTS];
        logic [FILL_W-1:0]  filled;
        tt_result_t         awaited[$];
        int errors = 0;
        int requests = 0;
        int probes = 0;
        int hits = 0;
        int exact_returns = 0;
        int beta_returns = 0;
        int stores_written = 0;
        int stores_refused = 0;

        function new();
            foreach (slot_valid[i])
            begin
                slot_valid[i] = 1'b0;
                slot_kind[i]  = KIND_ALL;
                slot_depth[i] = 8'd0;
            end
            filled = '0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void log_request(tt_request_t r);
            tt_result_t          want;
            logic [TBL_BITS-1:0] idx;
            int                  lo_v;
            int                  hi_v;
            int                  sc;
            logic                replace;
            want = '0;
            idx = r.key[TBL_BITS-1:0];
            requests++;
            if (r.req == REQ_PROBE)
            begin
                probes++;
                lo_v = r.w_lo;
                hi_v = r.w_hi;
                if (slot_valid[idx] && slot_tag[idx] == r.key)
                begin
                    hits++;
                    want.hit = 1'b1;
                    want.hint = slot_move[idx];
                    if (slot_depth[idx] >= r.depth)
                    begin
                        sc = slot_score[idx];
                        if (slot_kind[idx] == KIND_EXACT)
                        begin
                            want.outcome = OUT_EXACT;
                            want.ret = sc;
                            exact_returns++;
                        end
                        else
                        begin
                            if (slot_kind[idx] == KIND_CUT && sc > lo_v)
                                lo_v = sc;
                            else if (slot_kind[idx] == KIND_ALL && sc < hi_v)
                                hi_v = sc;
                            if (lo_v >= hi_v)
                            begin
                                want.outcome = OUT_BETA;
                                want.ret = hi_v;
                                beta_returns++;
                            end
                        end
                    end
                end
                want.adj_lo = lo_v;
                want.adj_hi = hi_v;
            end
            else
            begin
                replace = (!slot_valid[idx] || slot_kind[idx] != KIND_EXACT)
                          && slot_depth[idx] <= r.depth;
                if (replace)
                begin
                    if (!slot_valid[idx] && filled != FILL_MAX)
                        filled++;
                    slot_valid[idx] = 1'b1;
                    slot_tag[idx]   = r.key;
                    slot_move[idx]  = r.mv;
                    slot_score[idx] = r.val;
                    slot_kind[idx]  = r.kind;
                    slot_depth[idx] = r.depth;
                    want.written = 1'b1;
                    stores_written++;
                end
                else
                    stores_refused++;
            end
            want.fill = filled;
            awaited.push_back(want);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_response(tt_result_t got);
            tt_result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                $display("%0t response with nothing pending: expected none, actual %h",
                         $time, got);
                return;
            end
            want = awaited.pop_front();
            check_field("hit", want.hit, got.hit);
            check_field("hint_move", want.hint, got.hint);
            check_field("outcome", want.outcome, got.outcome);
            check_field("adjusted_low", want.adj_lo, got.adj_lo);
            check_field("adjusted_high", want.adj_hi, got.adj_hi);
            check_field("return_value", want.ret, got.ret);
            check_field("written", want.written, got.written);
            check_field("fill_count", want.fill, got.fill);
        endfunction
    endclass

    // DUT-facing signals; the inputs driven here are known from time zero
    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic                      req_type = REQ_PROBE;
    logic [63:0]               key = '0;
    logic [7:0]                remaining_depth = '0;
    logic signed [31:0]        window_low = '0;
    logic signed [31:0]        window_high = '0;
    logic signed [31:0]        entry_value = '0;
    logic [1:0]                entry_kind = KIND_ALL;
    logic [31:0]               entry_move = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic                      hit;
    logic [31:0]               hint_move;
    logic [1:0]                outcome;
    logic signed [31:0]        adjusted_low;
    logic signed [31:0]        adjusted_high;
    logic signed [31:0]        return_value;
    logic                      written;
    logic [FILL_W-1:0]         fill_count;

    table_shadow shadow;
    logic [63:0] key_pool [POOL_SIZE];
    // Traffic shaping shared between the request driver and the result sink
    logic        no_idle = 1'b0;
    logic        hold_req = 1'b0;
    int unsigned quiet_cycles = 0;

    transposition_table_engine #(
        .INDEX_BITS(TBL_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .key(key),
        .remaining_depth(remaining_depth),
        .window_low(window_low),
        .window_high(window_high),
        .entry_value(entry_value),
        .entry_kind(entry_kind),
        .entry_move(entry_move),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .hint_move(hint_move),
        .outcome(outcome),
        .adjusted_low(adjusted_low),
        .adjusted_high(adjusted_high),
        .return_value(return_value),
        .written(written),
        .fill_count(fill_count)
    );

    always #HALF_PERIOD clk = ~clk;

    // Idle lengths: mostly none or short, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Scores cluster near zero so bounds interact with windows; extremes show up too
    function automatic logic signed [31:0] rand_score();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $signed(32'($urandom_range(0, 128))) - 32'sd64;
        if (roll < 85)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return S32_MIN;
            1: return S32_MIN + 32'sd1;
            2: return S32_MAX - 32'sd1;
            default: return S32_MAX;
        endcase
    endfunction

    // Shallow depths dominate so stored depth often covers the probe
    function automatic logic [7:0] rand_depth();
        if ($urandom_range(0, 99) < 75)
            return 8'($urandom_range(0, 12));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [1:0] rand_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return KIND_SPARE;
        if (roll < 25)
            return KIND_EXACT;
        return (roll < 62) ? KIND_ALL : KIND_CUT;
    endfunction

    function automatic logic [63:0] pick_key();
        if ($urandom_range(0, 99) < 70)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    // Store-only fields of a probe carry noise, and the other way round
    function automatic tt_request_t mk_probe(logic [63:0] k, logic [7:0] d,
                                             logic signed [31:0] lo, logic signed [31:0] hi);
        return '{REQ_PROBE, k, d, lo, hi, $urandom, 2'($urandom), $urandom};
    endfunction

    function automatic tt_request_t mk_store(logic [63:0] k, logic [7:0] d, logic [1:0] kd,
                                             logic signed [31:0] v, logic [31:0] m);
        return '{REQ_STORE, k, d, $urandom, $urandom, v, kd, m};
    endfunction

    // Mostly ordered windows; the rest random, which often closes them
    function automatic tt_request_t rand_probe(logic [63:0] k);
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        lo = rand_score();
        if ($urandom_range(0, 99) < 80)
            hi = lo + $signed(32'($urandom_range(0, 100)));
        else
            hi = rand_score();
        return mk_probe(k, rand_depth(), lo, hi);
    endfunction

    function automatic tt_request_t rand_request();
        if ($urandom_range(0, 99) < 45)
            return mk_store(pick_key(), rand_depth(), rand_kind(), rand_score(), $urandom);
        return rand_probe(pick_key());
    endfunction

    // Offers one request and returns at the edge where it transfers.
    // Valid stays high between back-to-back requests.
    task automatic send_req(input tt_request_t r);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type        <= r.req;
        key             <= r.key;
        remaining_depth <= r.depth;
        window_low      <= r.w_lo;
        window_high     <= r.w_hi;
        entry_value     <= r.val;
        entry_kind      <= r.kind;
        entry_move      <= r.mv;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
    endtask

    // Transfer monitor: both channels sampled at the edge, before any NBA update
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_stall === 1'b0)
                shadow.log_request('{req_type, key, remaining_depth, window_low,
                                     window_high, entry_value, entry_kind, entry_move});
            if (out_valid === 1'b1 && !out_stall)
                shadow.check_response('{hit, hint_move, outcome, adjusted_low,
                                        adjusted_high, return_value, written, fill_count});
        end
    end

    // Result sink: random stall runs, a free-flowing mode, and one long hold-off
    // that lets the engine back up into its request port.
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (no_idle || stall_left == 0)
            begin
                out_stall <= 1'b0;
                stall_left = 0;
                if (!no_idle && $urandom_range(0, 99) < 35)
                    stall_left = pick_gap();
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
        end
    end

    // Watchdog: a run of edges with no transfer on either side means a hang
    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("[transposition_table_engine] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] k;
        logic [63:0] all_ones;
        logic [63:0] clash;
        int          sent;
        logic        hold_done;
        shadow = new();
        all_ones = '1;
        // Same slot as all_ones, different tag
        clash = 64'h1234_0000_0000_03FF;
        sent = 0;
        hold_done = 1'b0;

        // Pool: first half random, second half reuses the index bits with new tags
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (i < POOL_SIZE / 2)
                key_pool[i] = {$urandom, $urandom};
            else
                key_pool[i] = {$urandom, key_pool[i - POOL_SIZE / 2][31:0]}
                              ^ 64'h8000_0000_0000_0000;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // Empty slot: miss, widest window echoed
        send_req(mk_probe(64'd0, 8'd0, S32_MIN, S32_MAX));
        // Fill from empty at depth zero with an exact bound
        send_req(mk_store(64'd0, 8'd0, KIND_EXACT, S32_MAX, 32'hFFFF_FFFF));
        send_req(mk_probe(64'd0, 8'd0, S32_MIN, S32_MAX));
        // Stored depth too shallow: hit, hint only
        send_req(mk_probe(64'd0, 8'd1, S32_MIN, S32_MAX));
        // Exact entries are never replaced, even by a deeper store
        send_req(mk_store(64'd0, 8'd255, KIND_CUT, 32'sd0, 32'd0));
        // Cut bound at top index, deepest depth
        send_req(mk_store(all_ones, 8'd255, KIND_CUT, -32'sd100, 32'd0));
        send_req(mk_probe(all_ones, 8'd255, -32'sd200, 32'sd50));
        send_req(mk_probe(all_ones, 8'd17, -32'sd50, 32'sd50));
        // Raised alpha meets beta: return beta
        send_req(mk_probe(all_ones, 8'd0, -32'sd300, -32'sd150));
        // Non-exact slot replaced at equal depth with an all bound
        send_req(mk_store(all_ones, 8'd255, KIND_ALL, 32'sd40, 32'h8000_0001));
        send_req(mk_probe(all_ones, 8'd200, 32'sd0, 32'sd100));
        send_req(mk_probe(all_ones, 8'd200, 32'sd60, 32'sd100));
        // Window already closed, bound leaves it alone
        send_req(mk_probe(all_ones, 8'd200, 32'sd10, 32'sd10));
        // Other tag into the same slot, spare kind
        send_req(mk_store(clash, 8'd255, KIND_SPARE, S32_MIN, 32'h5A5A_A5A5));
        send_req(mk_probe(all_ones, 8'd0, S32_MIN, S32_MAX));
        send_req(mk_probe(clash, 8'd0, 32'sd5, 32'sd5));
        send_req(mk_probe(clash, 8'd0, 32'sd0, 32'sd5));
        // Shallower store refused, equal depth accepted
        send_req(mk_store(clash, 8'd254, KIND_CUT, 32'sd7, 32'd1));
        send_req(mk_store(clash, 8'd255, KIND_EXACT, S32_MIN, 32'd2));
        // Exact hit with an inverted window: window echoed
        send_req(mk_probe(clash, 8'd255, S32_MAX, S32_MIN));
        send_req(mk_store(64'd0, 8'd255, KIND_EXACT, 32'sd1, 32'd3));
        // Index of key zero, top tag bit set: miss
        send_req(mk_probe(64'h8000_0000_0000_0000, 8'd255, S32_MAX, S32_MIN));

        // --- random ---
        while (sent < RANDOM_ITEMS)
        begin
            no_idle = (sent >= 300 && sent < 360);
            if (!hold_done && sent >= 120)
            begin
                // Receiver holds off while requests keep coming back to back
                hold_done = 1'b1;
                hold_req = 1'b1;
                no_idle = 1'b1;
                repeat (HOLD_ITEMS) send_req(rand_request());
                sent += HOLD_ITEMS;
            end
            else if ($urandom_range(0, 99) < 40)
            begin
                // Store followed by a probe of the same position
                k = pick_key();
                send_req(mk_store(k, rand_depth(), rand_kind(), rand_score(), $urandom));
                send_req(rand_probe(k));
                sent += 2;
            end
            else
            begin
                send_req(rand_request());
                sent++;
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (shadow.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests: %0d probes, %0d hits, %0d exact returns, %0d beta returns",
                 shadow.requests, shadow.probes, shadow.hits, shadow.exact_returns,
                 shadow.beta_returns);
        $display("Stores: %0d written, %0d refused; %0d slots filled; %0d mismatches",
                 shadow.stores_written, shadow.stores_refused, shadow.filled, shadow.errors);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("[transposition_table_engine] OK");
        else
            $display("[transposition_table_engine] ERROR");
        $finish;
    end

endmodule
